FILE: design/rssd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rssd_pkg
// Shared types, constants and decode helpers for the RTC snapshot decoder.
// ----------------------------------------------------------------------------
package rssd_pkg;

    localparam int BYTE_W       = 8;
    localparam int PIVOT_W      = 14;
    localparam int YEAR_W       = 15;
    localparam int CFG_INDEX_W  = 1;
    localparam int CFG_DATA_W   = 14;
    localparam int IN_DATA_W    = 64;
    localparam int IN_USER_W    = 1;
    localparam int OUT_DATA_W   = 56;
    localparam int SNAP_W       = 56;
    localparam int QUEUE_DEPTH  = 2;
    localparam int QUEUE_PTR_W  = 1;
    localparam int QUEUE_CNT_W  = 2;

    // Register indexes on the configuration port
    localparam logic [CFG_INDEX_W-1:0] REG_CENTURY_INDEX = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PIVOT_YEAR    = 1'd1;

    localparam logic [PIVOT_W-1:0] PIVOT_RESET   = 14'd2016;
    localparam logic [BYTE_W-1:0]  PIVOT_Q_RESET = 8'd20;

    // Reciprocal of 100 scaled by 2^19; exact quotient for any 14-bit value
    localparam logic [26:0] RECIP_100   = 27'd5243;
    localparam int          RECIP_SHIFT = 19;

    localparam logic [BYTE_W-1:0] LOW_NIB   = 8'h0F;
    localparam logic [BYTE_W-1:0] HOUR_TENS = 8'h70;
    localparam logic [BYTE_W-1:0] PM_FLAG   = 8'h80;
    localparam logic [BYTE_W-1:0] HOUR_MASK = 8'h7F;
    localparam int                BIN_BIT   = 2;
    localparam int                H24_BIT   = 1;

    typedef struct packed {
        logic [BYTE_W-1:0] cen;
        logic [BYTE_W-1:0] yr;
        logic [BYTE_W-1:0] mon;
        logic [BYTE_W-1:0] day;
        logic [BYTE_W-1:0] hr;
        logic [BYTE_W-1:0] min;
        logic [BYTE_W-1:0] sec;
        logic              bin_mode;
        logic              h24_mode;
        logic              has_century;
    } rssd_entry_t;

    function automatic logic [BYTE_W-1:0] bcd_to_bin(input logic [BYTE_W-1:0] v);
        logic [BYTE_W-1:0] lo;
        logic [BYTE_W-1:0] hi;
        lo = v & LOW_NIB;
        hi = (v >> 4) & LOW_NIB;
        return lo + (hi << 3) + (hi << 1);
    endfunction

    // Tens digit is bits 6..4; PM flag is kept
    function automatic logic [BYTE_W-1:0] bcd_hours(input logic [BYTE_W-1:0] v);
        logic [BYTE_W-1:0] lo;
        logic [BYTE_W-1:0] hi;
        lo = v & LOW_NIB;
        hi = (v & HOUR_TENS) >> 4;
        return (lo + (hi << 3) + (hi << 1)) | (v & PM_FLAG);
    endfunction

    // Valid for inputs below 192
    function automatic logic [4:0] mod24(input logic [BYTE_W-1:0] x);
        logic [BYTE_W-1:0] r;
        r = x;
        if (r >= 8'd96)
        begin
            r = r - 8'd96;
        end
        if (r >= 8'd48)
        begin
            r = r - 8'd48;
        end
        if (r >= 8'd24)
        begin
            r = r - 8'd24;
        end
        return r[4:0];
    endfunction

endpackage

FILE: design/rtc_stable_snapshot_decoder_top.sv
`timescale 1ns / 1ps
// Path: a confirmed snapshot goes through the queue into the output
//   register that drives m_tvalid; other snapshots give no result.
// Throughput: one snapshot per cycle while the queue has room and the
//   output register is not stalled by m_tready.
// Reset: stored snapshot cleared to zero, century index 0, pivot year 2016,
//   queue and output register empty.
// ----------------------------------------------------------------------------
// rtc_stable_snapshot_decoder_top
// Decodes stable RTC register snapshots into binary date and full year.
// ----------------------------------------------------------------------------
module rtc_stable_snapshot_decoder_top
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wen,
    input  logic [rssd_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [rssd_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // raw_seconds, raw_minutes, raw_hours, raw_day, raw_month, raw_year,
    // raw_century, status_b
    input  logic [rssd_pkg::IN_DATA_W-1:0]      s_tdata,
    // update_in_progress
    input  logic [rssd_pkg::IN_USER_W-1:0]      s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // seconds, minutes, hours, day, month, full_year, zero pad
    output logic [rssd_pkg::OUT_DATA_W-1:0]     m_tdata
);

    logic [rssd_pkg::BYTE_W-1:0]    century_index_reg;
    logic [rssd_pkg::BYTE_W-1:0]    century_index_next;
    logic [rssd_pkg::PIVOT_W-1:0]   pivot_year_reg;
    logic [rssd_pkg::PIVOT_W-1:0]   pivot_year_next;
    logic [rssd_pkg::BYTE_W-1:0]    pivot_q_reg;
    logic [rssd_pkg::BYTE_W-1:0]    pivot_q_next;
    logic [26:0]                    recip_prod;

    logic                           push;
    logic                           pop;
    logic                           q_full;
    logic                           q_not_empty;
    rssd_pkg::rssd_entry_t          push_entry;
    rssd_pkg::rssd_entry_t          head_entry;

    // Quotient of pivot by 100, taken once at the write
    assign recip_prod = 27'(cfg_data) * rssd_pkg::RECIP_100;

    always_comb
    begin
        century_index_next = century_index_reg;
        pivot_year_next    = pivot_year_reg;
        pivot_q_next       = pivot_q_reg;
        if (cfg_wen)
        begin
            case (cfg_index)
                rssd_pkg::REG_CENTURY_INDEX:
                begin
                    century_index_next = cfg_data[7:0];
                end
                rssd_pkg::REG_PIVOT_YEAR:
                begin
                    pivot_year_next = cfg_data;
                    pivot_q_next    = recip_prod[26:rssd_pkg::RECIP_SHIFT];
                end
                default:
                begin
                    century_index_next = century_index_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            century_index_reg <= '0;
            pivot_year_reg    <= rssd_pkg::PIVOT_RESET;
            pivot_q_reg       <= rssd_pkg::PIVOT_Q_RESET;
        end
        else
        begin
            century_index_reg <= century_index_next;
            pivot_year_reg    <= pivot_year_next;
            pivot_q_reg       <= pivot_q_next;
        end
    end

    rssd_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .century_index (century_index_reg),
        .q_full        (q_full),
        .push          (push),
        .push_entry    (push_entry)
    );

    rssd_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (pop),
        .not_empty  (q_not_empty),
        .head_entry (head_entry)
    );

    rssd_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .head_entry  (head_entry),
        .pop         (pop),
        .pivot_year  (pivot_year_reg),
        .pivot_q     (pivot_q_reg),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

endmodule

FILE: design/rssd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rssd_front
// Accepts snapshots, filters update-in-progress reads, compares with the
// stored snapshot and forwards confirmed snapshots to the queue.
// ----------------------------------------------------------------------------
module rssd_front
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // raw_seconds, raw_minutes, raw_hours, raw_day, raw_month, raw_year,
    // raw_century, status_b
    input  logic [rssd_pkg::IN_DATA_W-1:0]    s_tdata,
    // update_in_progress
    input  logic [rssd_pkg::IN_USER_W-1:0]    s_tuser,
    input  logic [rssd_pkg::BYTE_W-1:0]       century_index,
    input  logic                              q_full,
    output logic                              push,
    output rssd_pkg::rssd_entry_t             push_entry
);

    logic [rssd_pkg::SNAP_W-1:0] last_snap_reg;
    logic [rssd_pkg::SNAP_W-1:0] last_snap_next;
    logic [rssd_pkg::SNAP_W-1:0] snap;
    logic [rssd_pkg::BYTE_W-1:0] status_b;
    logic                        has_century;
    logic                        accept;
    logic                        live;
    logic                        match;

    assign s_tready    = !q_full;
    assign accept      = s_tvalid && s_tready;
    assign live        = accept && !s_tuser[0];
    assign has_century = century_index != '0;
    assign status_b    = s_tdata[63:56];

    // Without a century register the stored byte is kept and always matches
    assign snap  = {has_century ? s_tdata[55:48] : last_snap_reg[55:48], s_tdata[47:0]};
    assign match = snap == last_snap_reg;
    assign push  = live && match;

    always_comb
    begin
        last_snap_next = last_snap_reg;
        if (live && !match)
        begin
            last_snap_next = snap;
        end
    end

    always_comb
    begin
        push_entry.sec         = snap[7:0];
        push_entry.min         = snap[15:8];
        push_entry.hr          = snap[23:16];
        push_entry.day         = snap[31:24];
        push_entry.mon         = snap[39:32];
        push_entry.yr          = snap[47:40];
        push_entry.cen         = snap[55:48];
        push_entry.bin_mode    = status_b[rssd_pkg::BIN_BIT];
        push_entry.h24_mode    = status_b[rssd_pkg::H24_BIT];
        push_entry.has_century = has_century;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_snap_reg <= '0;
        end
        else
        begin
            last_snap_reg <= last_snap_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_push_only_on_match : assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (accept && !s_tuser[0] && snap == last_snap_reg))
        else $error("push without a confirmed snapshot");

    a_store_on_mismatch : assert property (@(posedge clk) disable iff (!rst_n)
        (live && !match) |=> (last_snap_reg == $past(snap)))
        else $error("mismatching snapshot not stored");

    a_hold_when_ignored : assert property (@(posedge clk) disable iff (!rst_n)
        (!live) |=> $stable(last_snap_reg))
        else $error("stored snapshot changed without a live request");
`endif

endmodule

FILE: design/rssd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rssd_queue
// Two-entry queue between the front and back halves.
// ----------------------------------------------------------------------------
module rssd_queue
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  rssd_pkg::rssd_entry_t push_entry,
    output logic                  full,
    input  logic                  pop,
    output logic                  not_empty,
    output rssd_pkg::rssd_entry_t head_entry
);

    rssd_pkg::rssd_entry_t                mem [rssd_pkg::QUEUE_DEPTH];
    logic [rssd_pkg::QUEUE_PTR_W-1:0]     wr_ptr_reg;
    logic [rssd_pkg::QUEUE_PTR_W-1:0]     wr_ptr_next;
    logic [rssd_pkg::QUEUE_PTR_W-1:0]     rd_ptr_reg;
    logic [rssd_pkg::QUEUE_PTR_W-1:0]     rd_ptr_next;
    logic [rssd_pkg::QUEUE_CNT_W-1:0]     count_reg;
    logic [rssd_pkg::QUEUE_CNT_W-1:0]     count_next;

    assign full       = count_reg == rssd_pkg::QUEUE_CNT_W'(rssd_pkg::QUEUE_DEPTH);
    assign not_empty  = count_reg != '0;
    assign head_entry = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow : assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("push into full queue");

    a_no_underflow : assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("pop from empty queue");

    a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= rssd_pkg::QUEUE_CNT_W'(rssd_pkg::QUEUE_DEPTH))
        else $error("queue count out of range");
`endif

endmodule

FILE: design/rssd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rssd_back
// Decodes a confirmed snapshot into binary date fields and a full year and
// holds the result in the output register.
// ----------------------------------------------------------------------------
module rssd_back
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              q_not_empty,
    input  rssd_pkg::rssd_entry_t             head_entry,
    output logic                              pop,
    input  logic [rssd_pkg::PIVOT_W-1:0]      pivot_year,
    input  logic [rssd_pkg::BYTE_W-1:0]       pivot_q,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // seconds, minutes, hours, day, month, full_year, zero pad
    output logic [rssd_pkg::OUT_DATA_W-1:0]   m_tdata
);

    logic                              valid_reg;
    logic                              valid_next;
    logic [rssd_pkg::OUT_DATA_W-1:0]   data_reg;
    logic [rssd_pkg::BYTE_W-1:0]       sec;
    logic [rssd_pkg::BYTE_W-1:0]       min;
    logic [rssd_pkg::BYTE_W-1:0]       hr_dec;
    logic [rssd_pkg::BYTE_W-1:0]       hr;
    logic [rssd_pkg::BYTE_W-1:0]       day;
    logic [rssd_pkg::BYTE_W-1:0]       mon;
    logic [rssd_pkg::BYTE_W-1:0]       yr;
    logic [rssd_pkg::BYTE_W-1:0]       cen;
    logic [rssd_pkg::BYTE_W-1:0]       mult_in;
    logic [rssd_pkg::YEAR_W-1:0]       base;
    logic [rssd_pkg::YEAR_W-1:0]       sum;
    logic [rssd_pkg::YEAR_W-1:0]       full_year;
    logic                              pm_wrap;

    assign pop = q_not_empty && (!valid_reg || m_tready);

    always_comb
    begin
        if (head_entry.bin_mode)
        begin
            sec    = head_entry.sec;
            min    = head_entry.min;
            hr_dec = head_entry.hr;
            day    = head_entry.day;
            mon    = head_entry.mon;
            yr     = head_entry.yr;
            cen    = head_entry.cen;
        end
        else
        begin
            sec    = rssd_pkg::bcd_to_bin(head_entry.sec);
            min    = rssd_pkg::bcd_to_bin(head_entry.min);
            hr_dec = rssd_pkg::bcd_hours(head_entry.hr);
            day    = rssd_pkg::bcd_to_bin(head_entry.day);
            mon    = rssd_pkg::bcd_to_bin(head_entry.mon);
            yr     = rssd_pkg::bcd_to_bin(head_entry.yr);
            cen    = rssd_pkg::bcd_to_bin(head_entry.cen);
        end
    end

    // Map 12-hour PM to 24-hour form
    assign pm_wrap = !head_entry.h24_mode && hr_dec[7];

    always_comb
    begin
        if (pm_wrap)
        begin
            hr = {3'b000, rssd_pkg::mod24((hr_dec & rssd_pkg::HOUR_MASK) + 8'd12)};
        end
        else
        begin
            hr = hr_dec;
        end
    end

    // Century, or the pivot's quotient by 100, times 100 as shifts and adds
    assign mult_in = head_entry.has_century ? cen : pivot_q;
    assign base    = (rssd_pkg::YEAR_W'(mult_in) << 6) + (rssd_pkg::YEAR_W'(mult_in) << 5)
                   + (rssd_pkg::YEAR_W'(mult_in) << 2);
    assign sum     = base + rssd_pkg::YEAR_W'(yr);

    always_comb
    begin
        full_year = sum;
        if (!head_entry.has_century && sum < rssd_pkg::YEAR_W'(pivot_year))
        begin
            full_year = sum + 15'd100;
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (pop)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            data_reg <= {1'b0, full_year, mon, day, hr, min, sec};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;

`ifndef NO_ASSERTIONS
    a_pm_hours_range : assert property (@(posedge clk) disable iff (!rst_n)
        (pop && pm_wrap) |=> (data_reg[23:16] < 8'd24))
        else $error("converted PM hour out of range");

    a_pivot_floor : assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !head_entry.has_century) |=>
            (data_reg[54:40] >= rssd_pkg::YEAR_W'(pivot_year)))
        else $error("pivot year not honoured");

    a_pop_needs_room : assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !m_tready) |-> !pop)
        else $error("output register overwritten while stalled");
`endif

endmodule

FILE: sim/rtc_date_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtc_date_checker
// Watches the configuration port and both stream channels of the RTC snapshot
// decoder, keeps its own copy of the stored snapshot and registers, predicts
// the date each confirmed snapshot yields and compares every result with it.
// ----------------------------------------------------------------------------
module rtc_date_checker
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wen,
    input  logic [rssd_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [rssd_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                s_tvalid,
    input  logic                                s_tready,
    input  logic [rssd_pkg::IN_DATA_W-1:0]      s_tdata,
    input  logic [rssd_pkg::IN_USER_W-1:0]      s_tuser,
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic [rssd_pkg::OUT_DATA_W-1:0]     m_tdata,
    output int                                  outstanding,
    output int                                  fail_count
);

    import rssd_pkg::*;

    typedef struct packed {
        logic [7:0]  sec;
        logic [7:0]  minute;
        logic [7:0]  hour;
        logic [7:0]  day;
        logic [7:0]  month;
        logic [14:0] full_year;
    } rtc_date_t;

    logic [7:0]  held_snap [7];
    logic [7:0]  century_sel;
    logic [13:0] pivot;
    rtc_date_t   expected_dates [$];
    rtc_date_t   got_date;
    rtc_date_t   want_date;
    rtc_date_t   new_date;

    task automatic report(input string what);
        $display("%0t ns mismatch: %s", $time, what);
        fail_count++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
        begin
            report($sformatf("%s got %0d want %0d", name, got, want));
        end
    endtask

    // Nibbles taken as they stand, invalid BCD included
    function automatic int bcd_value(input logic [7:0] v);
        return int'(v[3:0]) + int'(v[7:4]) * 10;
    endfunction

    // Store a new snapshot, or decode it when it repeats the stored one
    function automatic bit confirm_snapshot(input logic [63:0] raw, output rtc_date_t d);
        logic [7:0] snap [7];
        logic [7:0] sb;
        bit         same;
        int         sec_v;
        int         min_v;
        int         hr_v;
        int         day_v;
        int         mon_v;
        int         yr_v;
        int         cen_v;
        int         year_v;
        d = '0;
        same = 1'b1;
        sb = raw[63:56];
        for (int i = 0; i < 6; i++)
        begin
            snap[i] = raw[i*8 +: 8];
        end
        // without a century register the stored byte is kept and always matches
        snap[6] = (century_sel != 8'd0) ? raw[55:48] : held_snap[6];
        for (int i = 0; i < 7; i++)
        begin
            if (snap[i] != held_snap[i])
            begin
                same = 1'b0;
            end
        end
        if (!same)
        begin
            for (int i = 0; i < 7; i++)
            begin
                held_snap[i] = snap[i];
            end
            return 1'b0;
        end
        if (!sb[BIN_BIT])
        begin
            sec_v = bcd_value(snap[0]);
            min_v = bcd_value(snap[1]);
            hr_v  = int'(snap[2][3:0]) + int'(snap[2][6:4]) * 10 + (snap[2][7] ? 128 : 0);
            day_v = bcd_value(snap[3]);
            mon_v = bcd_value(snap[4]);
            yr_v  = bcd_value(snap[5]);
            cen_v = bcd_value(snap[6]);
        end
        else
        begin
            sec_v = snap[0];
            min_v = snap[1];
            hr_v  = snap[2];
            day_v = snap[3];
            mon_v = snap[4];
            yr_v  = snap[5];
            cen_v = snap[6];
        end
        if (!sb[H24_BIT] && (hr_v & 128) != 0)
        begin
            hr_v = ((hr_v & 127) + 12) % 24;
        end
        if (century_sel != 8'd0)
        begin
            year_v = yr_v + cen_v * 100;
        end
        else
        begin
            year_v = yr_v + (int'(pivot) / 100) * 100;
            if (year_v < int'(pivot))
            begin
                year_v += 100;
            end
        end
        d.sec       = sec_v[7:0];
        d.minute    = min_v[7:0];
        d.hour      = hr_v[7:0];
        d.day       = day_v[7:0];
        d.month     = mon_v[7:0];
        d.full_year = year_v[14:0];
        return 1'b1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 7; i++)
            begin
                held_snap[i] = 8'd0;
            end
            century_sel = 8'd0;
            pivot = PIVOT_RESET;
            expected_dates.delete();
            fail_count = 0;
            outstanding <= 0;
        end
        else
        begin
            // results first: a request accepted at this edge cannot answer here
            if (m_tvalid && m_tready)
            begin
                got_date.sec       = m_tdata[7:0];
                got_date.minute    = m_tdata[15:8];
                got_date.hour      = m_tdata[23:16];
                got_date.day       = m_tdata[31:24];
                got_date.month     = m_tdata[39:32];
                got_date.full_year = m_tdata[54:40];
                if (expected_dates.size() == 0)
                begin
                    report("date emitted with none pending");
                end
                else
                begin
                    want_date = expected_dates.pop_front();
                    check_field("seconds", got_date.sec, want_date.sec);
                    check_field("minutes", got_date.minute, want_date.minute);
                    check_field("hours", got_date.hour, want_date.hour);
                    check_field("day", got_date.day, want_date.day);
                    check_field("month", got_date.month, want_date.month);
                    check_field("full_year", got_date.full_year, want_date.full_year);
                end
            end
            if (s_tvalid && s_tready && !s_tuser[0])
            begin
                if (confirm_snapshot(s_tdata, new_date))
                begin
                    expected_dates.push_back(new_date);
                end
            end
            if (cfg_wen)
            begin
                if (cfg_index == REG_CENTURY_INDEX)
                begin
                    century_sel = cfg_data[7:0];
                end
                else if (cfg_index == REG_PIVOT_YEAR)
                begin
                    pivot = cfg_data;
                end
            end
            outstanding <= expected_dates.size();
        end
    end

endmodule

FILE: sim/tb_rtc_stable_snapshot_decoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rtc_stable_snapshot_decoder_top
// Drives RTC register snapshots into the decoder: a directed set covering the
// decode corner cases, then random snapshot streams under several century and
// pivot settings, with random gaps on both channels. The checker beside the
// block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_rtc_stable_snapshot_decoder_top;

    import rssd_pkg::*;

    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 126;

    logic                       clk       = 1'b0;
    logic                       rst_n     = 1'b0;
    logic                       cfg_wen   = 1'b0;
    logic [CFG_INDEX_W-1:0]     cfg_index = '0;
    logic [CFG_DATA_W-1:0]      cfg_data  = '0;
    logic                       s_tvalid  = 1'b0;
    logic                       s_tready;
    logic [IN_DATA_W-1:0]       s_tdata   = '0;
    logic [IN_USER_W-1:0]       s_tuser   = '0;
    logic                       m_tvalid;
    logic                       m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0]      m_tdata;
    int                         outstanding;
    int                         fail_count;
    bit                         send_burst = 1'b0;
    bit                         recv_burst = 1'b0;

    always #5 clk = ~clk;

    rtc_stable_snapshot_decoder_top uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    rtc_date_checker date_checker
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wen     (cfg_wen),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .outstanding (outstanding),
        .fail_count  (fail_count)
    );

    function automatic logic [63:0] pack_snapshot(input logic [7:0] sec, input logic [7:0] minute,
                                                  input logic [7:0] hour, input logic [7:0] day,
                                                  input logic [7:0] month, input logic [7:0] yr,
                                                  input logic [7:0] cen, input logic [7:0] sb);
        return {sb, cen, yr, month, day, hour, minute, sec};
    endfunction

    // Half fully random bytes, half valid BCD
    function automatic logic [7:0] random_field();
        int v;
        if ($urandom_range(0, 1) == 1)
        begin
            return 8'($urandom_range(0, 255));
        end
        v = $urandom_range(0, 99);
        return 8'((v / 10) * 16 + v % 10);
    endfunction

    function automatic logic [63:0] random_snapshot();
        logic [7:0] hour;
        hour = random_field();
        if ($urandom_range(0, 2) == 0)
        begin
            hour[7] = 1'b1;
        end
        return pack_snapshot(random_field(), random_field(), hour, random_field(),
                             random_field(), random_field(), random_field(),
                             8'($urandom_range(0, 255)));
    endfunction

    task automatic send_snapshot(input bit uip, input logic [63:0] payload);
        int gap;
        if ($urandom_range(0, 39) == 0)
        begin
            send_burst = !send_burst;
        end
        gap = send_burst ? 0 : $urandom_range(0, 16);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= payload;
        s_tuser  <= uip;
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic send_pair(input logic [63:0] payload);
        send_snapshot(1'b0, payload);
        send_snapshot(1'b0, payload);
    endtask

    // Hold the sender until every pending date is out and the pipe is quiet
    task automatic hold_until_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        hold_until_drained();
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_wen   <= 1'b0;
    endtask

    initial
    begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        int stall;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 39) == 0)
            begin
                recv_burst = !recv_burst;
            end
            stall = recv_burst ? 0 : $urandom_range(0, 16);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    initial
    begin
        logic [63:0]           prev;
        logic [CFG_DATA_W-1:0] cen_cfg;
        logic [CFG_DATA_W-1:0] pivot_cfg;
        int                    sent;
        int                    roll;
        int                    pos;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: no century register, pivot 2016
        send_snapshot(1'b0, 64'd0);
        send_snapshot(1'b1, {64{1'b1}});
        send_pair(pack_snapshot(8'h59, 8'h59, 8'h92, 8'h31, 8'h12, 8'h99, 8'h20, 8'h00));
        send_pair({8'hFF, {7{8'hFF}}});
        send_pair({8'h00, {7{8'hFF}}});
        send_pair(pack_snapshot(8'h3B, 8'h3B, 8'h8B, 8'h1F, 8'h0C, 8'h10, 8'h00, 8'h04));
        send_pair(pack_snapshot(8'h00, 8'h00, 8'h85, 8'h01, 8'h01, 8'h16, 8'h00, 8'h02));
        // a busy read between two equal reads must not break the pair
        prev = pack_snapshot(8'h30, 8'h15, 8'h08, 8'h28, 8'h02, 8'h15, 8'h19, 8'h00);
        send_snapshot(1'b0, prev);
        send_snapshot(1'b1, random_snapshot());
        send_snapshot(1'b0, prev);
        send_snapshot(1'b0, pack_snapshot(8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h12, 8'h00));
        send_snapshot(1'b0, pack_snapshot(8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h34, 8'h00));

        write_register(REG_CENTURY_INDEX, 14'd255);
        write_register(REG_PIVOT_YEAR, 14'd9999);
        send_pair(pack_snapshot(8'h45, 8'h30, 8'h23, 8'h15, 8'h06, 8'h50, 8'h99, 8'h00));
        send_snapshot(1'b0, pack_snapshot(8'h10, 8'h10, 8'h10, 8'h10, 8'h10, 8'h10, 8'h20, 8'h00));
        send_snapshot(1'b0, pack_snapshot(8'h10, 8'h10, 8'h10, 8'h10, 8'h10, 8'h10, 8'h21, 8'h00));
        send_snapshot(1'b0, pack_snapshot(8'h10, 8'h10, 8'h10, 8'h10, 8'h10, 8'h10, 8'h21, 8'h00));

        // low byte zero: no century register despite upper bits set
        write_register(REG_CENTURY_INDEX, 14'h3F00);
        send_pair(pack_snapshot(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h04));
        write_register(REG_PIVOT_YEAR, 14'd0);
        send_pair({8'h06, {7{8'hFF}}});
        write_register(REG_CENTURY_INDEX, 14'd1);
        send_pair({8'h04, {7{8'hFF}}});

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:
                begin
                    cen_cfg   = 14'd0;
                    pivot_cfg = 14'd0;
                end
                1:
                begin
                    cen_cfg   = 14'd255;
                    pivot_cfg = 14'd9999;
                end
                2:
                begin
                    cen_cfg   = 14'd1;
                    pivot_cfg = 14'd2016;
                end
                3:
                begin
                    cen_cfg   = 14'h3F00;
                    pivot_cfg = 14'd9999;
                end
                default:
                begin
                    cen_cfg   = 14'($urandom_range(0, 16383));
                    pivot_cfg = 14'($urandom_range(0, 9999));
                end
            endcase
            write_register(REG_CENTURY_INDEX, cen_cfg);
            write_register(REG_PIVOT_YEAR, pivot_cfg);
            prev = random_snapshot();
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 10)
                begin
                    send_snapshot(1'b1, random_snapshot());
                    continue;
                end
                if (roll < 60)
                begin
                    // repeat the last read: status B is not compared; sometimes the century byte changes too
                    prev[63:56] = 8'($urandom_range(0, 255));
                    if (roll < 20)
                    begin
                        prev[55:48] = 8'($urandom_range(0, 255));
                    end
                end
                else if (roll < 70)
                begin
                    pos = $urandom_range(0, 6);
                    prev[pos*8 +: 8] = 8'($urandom_range(0, 255));
                end
                else
                begin
                    prev = random_snapshot();
                end
                send_snapshot(1'b0, prev);
                sent++;
                if (p == 2 && sent == PHASE_ITEMS / 2)
                begin
                    hold_until_drained();
                end
            end
        end

        s_tvalid <= 1'b0;
        @(posedge clk);
        for (int k = 0; k < 2000 && outstanding != 0; k++)
        begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);
        if (outstanding != 0)
        begin
            $display("%0d dates never emitted", outstanding);
        end
        if (fail_count == 0 && outstanding == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
